FILE: hw/rtl/rbia_pkg.sv
// shared constants and codes for the rotating bitmap id allocator
package rbia_pkg;

  localparam int unsigned NumIdsDefault = 1024;
  localparam int unsigned IdWidth       = 24;
  localparam int unsigned WordWidthMax  = 32;

  localparam logic [IdWidth-1:0] IdMaskReset = {IdWidth{1'b1}};

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFull = 1'b1;

endpackage

FILE: hw/rtl/rotating_bitmap_id_allocator_core.sv
// rotating bitmap id allocator: word-wide used map in a synchronous ram
//
// The used map lives in one RAM of NUM_IDS/32 words (fewer bits per word when
// NUM_IDS is below 32) with a registered read. One transaction is worked on at
// a time. A free reads the map word in the accepting cycle; in the evaluate state
// it writes the word back and loads the result register once the result register
// is free. An allocate reads the word under the search pointer and then each
// further word in turn until it finds a free entry; a search that wraps rereads
// the map from word 0. A stalled result delays the write back. After reset the
// map is cleared by a pass over every map word, during which no input is
// accepted; id_mask writes are taken at any time and are always ready.
module rotating_bitmap_id_allocator_core #(
  parameter int unsigned NUM_IDS = rbia_pkg::NumIdsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rbia_pkg::IdWidth-1:0] cfg_wdata_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [rbia_pkg::IdWidth-1:0] id_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic [rbia_pkg::IdWidth-1:0] assigned_id_o
);

  localparam int unsigned IdW   = rbia_pkg::IdWidth;
  localparam int unsigned IdxW  = $clog2(NUM_IDS);
  localparam int unsigned WordW = (NUM_IDS < rbia_pkg::WordWidthMax) ? NUM_IDS
                                                                      : rbia_pkg::WordWidthMax;
  localparam int unsigned Words = NUM_IDS / WordW;
  localparam int unsigned BitW  = $clog2(WordW);
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam logic [AddrW-1:0] LastWord = AddrW'(Words - 1);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StEval
  } state_e;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [AddrW-1:0]  word_q, word_d;
  logic [BitW-1:0]   bit_q, bit_d;
  logic              first_q, first_d;
  logic              wrap_q, wrap_d;
  logic              cmd_q, cmd_d;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  logic [IdW-1:0]    gen_q, gen_d;
  logic [IdW-1:0]    mask_q, mask_d;
  logic              out_valid_q, out_valid_d;
  logic              status_q, status_d;
  logic [IdW-1:0]    assigned_q, assigned_d;

  // used map ram
  logic [WordW-1:0]  mem_q [Words];
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic [WordW-1:0]  rd_data_q;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [WordW-1:0]  wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  logic [IdxW-1:0]   id_idx;
  logic [AddrW-1:0]  id_word, ptr_word;
  logic [BitW-1:0]   id_bit, ptr_bit;
  logic [WordW-1:0]  start_mask, free_vec;
  logic              found;
  logic [BitW-1:0]   found_bit;
  logic [IdxW-1:0]   slot;
  logic [IdW-1:0]    gen_bump;
  logic              out_free;

  assign id_idx   = id_i[IdxW-1:0];
  assign id_word  = AddrW'(id_idx >> BitW);
  assign id_bit   = id_idx[BitW-1:0];
  assign ptr_word = AddrW'(ptr_q >> BitW);
  assign ptr_bit  = ptr_q[BitW-1:0];

  // only the first word of the first pass skips entries below the pointer
  assign start_mask = first_q ? ({WordW{1'b1}} << bit_q) : {WordW{1'b1}};
  assign free_vec   = ~rd_data_q & start_mask;

  always_comb begin
    found     = 1'b0;
    found_bit = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found     = 1'b1;
        found_bit = BitW'(i);
      end
    end
  end

  assign slot     = IdxW'({word_q, found_bit});
  assign gen_bump = (gen_q + IdW'(NUM_IDS)) & mask_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    word_d      = word_q;
    bit_d       = bit_q;
    first_d     = first_q;
    wrap_d      = wrap_q;
    cmd_d       = cmd_q;
    ptr_d       = ptr_q;
    gen_d       = gen_q;
    mask_d      = cfg_valid_i ? cfg_wdata_i : mask_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    assigned_d  = assigned_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    case (state_q)
      StClear: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + AddrW'(1);
        if (clr_q == LastWord) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        if (in_valid_i) begin
          rd_en   = 1'b1;
          cmd_d   = command_i;
          first_d = 1'b1;
          wrap_d  = 1'b0;
          state_d = StEval;
          if (command_i == rbia_pkg::CmdFree) begin
            rd_addr = id_word;
            bit_d   = id_bit;
          end else begin
            rd_addr = ptr_word;
            bit_d   = ptr_bit;
          end
          word_d = rd_addr;
        end
      end

      StEval: begin
        if (cmd_q == rbia_pkg::CmdFree) begin
          if (out_free) begin
            wr_en       = 1'b1;
            wr_addr     = word_q;
            wr_data     = rd_data_q & ~(WordW'(1) << bit_q);
            gen_d       = gen_bump;
            out_valid_d = 1'b1;
            status_d    = rbia_pkg::StatusOk;
            assigned_d  = '0;
            state_d     = StIdle;
          end
        end else if (found) begin
          if (out_free) begin
            wr_en       = 1'b1;
            wr_addr     = word_q;
            wr_data     = rd_data_q | (WordW'(1) << found_bit);
            ptr_d       = slot + IdxW'(1);
            out_valid_d = 1'b1;
            status_d    = rbia_pkg::StatusOk;
            assigned_d  = IdW'(slot) | gen_q;
            state_d     = StIdle;
          end
        end else if (word_q != LastWord) begin
          rd_en   = 1'b1;
          rd_addr = word_q + AddrW'(1);
          word_d  = rd_addr;
          first_d = 1'b0;
        end else if (!wrap_q) begin
          // nothing at or above the pointer: new generation, rescan from zero
          gen_d   = gen_bump;
          wrap_d  = 1'b1;
          rd_en   = 1'b1;
          rd_addr = '0;
          word_d  = '0;
          first_d = 1'b0;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = rbia_pkg::StatusFull;
          assigned_d  = '0;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      ptr_q       <= '0;
      gen_q       <= '0;
      mask_q      <= rbia_pkg::IdMaskReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ptr_q       <= ptr_d;
      gen_q       <= gen_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    bit_q      <= bit_d;
    first_q    <= first_d;
    wrap_q     <= wrap_d;
    cmd_q      <= cmd_d;
    status_q   <= status_d;
    assigned_q <= assigned_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign assigned_id_o = assigned_q;

endmodule

FILE: hw/rtl/rbia_checker.sv
// port-level checks for the rotating bitmap id allocator, bound to the core
module rbia_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         status_o,
  input logic [rbia_pkg::IdWidth-1:0] assigned_id_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(assigned_id_o))
    else $error("stalled result changed");

  // a failed allocation never carries an id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rbia_pkg::StatusFull) |-> (assigned_id_o == '0))
    else $error("full status with nonzero id");

  // one transaction in flight: acceptance closes the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  // map clear runs right after reset, so no input is taken yet
  assert property (@(posedge clk_i)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input open during map clear");

endmodule

bind rotating_bitmap_id_allocator_core rbia_checker u_rbia_checker (.*);

FILE: sim/rotating_bitmap_id_allocator_core_tb.sv
// testbench for the rotating bitmap id allocator core: directed table, then random phases
`timescale 1ns / 100ps

module rotating_bitmap_id_allocator_core_tb;

  localparam int unsigned IdW       = rbia_pkg::IdWidth;
  localparam int unsigned NumIds    = rbia_pkg::NumIdsDefault;
  localparam int unsigned IndexBits = $clog2(NumIds);
  localparam int          Latency   = 2 * (NumIds / 32) + 8;
  localparam int          HoldOff   = 300;
  localparam int          NumRows   = 13;
  localparam int          NumPhases = 4;

  typedef struct packed {
    logic           status;
    logic [IdW-1:0] assigned_id;
  } alloc_result_t;

  typedef struct packed {
    logic           cmd;
    logic [IdW-1:0] id;
    logic           typed;
    logic           status;
    logic [IdW-1:0] assigned_id;
  } directed_row_t;

  // typed rows follow directly from the reset state and the default mask
  localparam directed_row_t DirectedRows [NumRows] = '{
    '{rbia_pkg::CmdAlloc, 24'hFFFFFF, 1'b1, rbia_pkg::StatusOk, 24'h000000},
    '{rbia_pkg::CmdAlloc, 24'h000000, 1'b1, rbia_pkg::StatusOk, 24'h000001},
    // top entry, never used
    '{rbia_pkg::CmdFree,  24'hFFFFFF, 1'b1, rbia_pkg::StatusOk, 24'h000000},
    '{rbia_pkg::CmdAlloc, 24'h5A5A5A, 1'b1, rbia_pkg::StatusOk, 24'h000402},
    '{rbia_pkg::CmdFree,  24'h000001, 1'b1, rbia_pkg::StatusOk, 24'h000000},
    // high bits ignored
    '{rbia_pkg::CmdFree,  24'hABC000, 1'b1, rbia_pkg::StatusOk, 24'h000000},
    '{rbia_pkg::CmdAlloc, 24'h000000, 1'b0, rbia_pkg::StatusOk, 24'h000000},
    '{rbia_pkg::CmdFree,  24'h000402, 1'b1, rbia_pkg::StatusOk, 24'h000000},
    // already free
    '{rbia_pkg::CmdFree,  24'h000402, 1'b1, rbia_pkg::StatusOk, 24'h000000},
    '{rbia_pkg::CmdAlloc, 24'hA5A5A5, 1'b0, rbia_pkg::StatusOk, 24'h000000},
    '{rbia_pkg::CmdAlloc, 24'h000000, 1'b0, rbia_pkg::StatusOk, 24'h000000},
    '{rbia_pkg::CmdFree,  24'h800003, 1'b1, rbia_pkg::StatusOk, 24'h000000},
    '{rbia_pkg::CmdAlloc, 24'hFFFFFF, 1'b0, rbia_pkg::StatusOk, 24'h000000}
  };

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [IdW-1:0] cfg_wdata_i = '0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  logic           command_i   = rbia_pkg::CmdAlloc;
  logic [IdW-1:0] id_i        = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  logic           status_o;
  logic [IdW-1:0] assigned_id_o;

  // allocator shadow state
  bit             used_bits [NumIds];
  int unsigned    search_ptr = 0;
  logic [IdW-1:0] gen_bits   = '0;
  logic [IdW-1:0] mask_bits  = rbia_pkg::IdMaskReset;
  logic [IdW-1:0] live_ids [$];

  alloc_result_t expected_results [$];
  alloc_result_t oldest_result;
  int            errors_seen = 0;
  bit            steady      = 1'b0;
  int            hold_req    = 0;

  always #6 clk_i = ~clk_i;

  rotating_bitmap_id_allocator_core #(
    .NUM_IDS(NumIds)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .id_i         (id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .assigned_id_o(assigned_id_o)
  );

  function automatic int unsigned find_free(input int unsigned from);
    for (int unsigned i = from; i < NumIds; i++) begin
      if (!used_bits[i]) return i;
    end
    return NumIds;
  endfunction

  function automatic void advance_generation();
    gen_bits = (gen_bits + IdW'(NumIds)) & mask_bits;
  endfunction

  // offer one request, wait until it is accepted, then update the shadow allocator
  task automatic issue_request(input logic cmd, input logic [IdW-1:0] req_id,
                               input bit typed, input alloc_result_t typed_result);
    alloc_result_t res;
    int unsigned   slot;
    if (!steady && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    id_i       <= req_id;
    do @(posedge clk_i); while (in_stall_o);
    res = '{status: rbia_pkg::StatusOk, assigned_id: '0};
    if (cmd == rbia_pkg::CmdFree) begin
      used_bits[req_id[IndexBits-1:0]] = 1'b0;
      advance_generation();
    end else begin
      slot = find_free(search_ptr);
      if (slot == NumIds) begin
        // nothing free at or above the pointer: new generation, rescan from zero
        advance_generation();
        slot = find_free(0);
      end
      if (slot < NumIds) begin
        search_ptr      = (slot + 1) % NumIds;
        used_bits[slot] = 1'b1;
        res.assigned_id = IdW'(slot) | gen_bits;
        live_ids.push_back(res.assigned_id);
      end else begin
        res.status = rbia_pkg::StatusFull;
      end
    end
    expected_results.push_back(typed ? typed_result : res);
  endtask

  task automatic wait_idle();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  initial begin
    logic [IdW-1:0] new_mask;
    logic [IdW-1:0] req_id;
    logic           cmd;
    int             count;
    int             alloc_pct;
    int             pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      issue_request(DirectedRows[r].cmd, DirectedRows[r].id, DirectedRows[r].typed,
                    '{status: DirectedRows[r].status,
                      assigned_id: DirectedRows[r].assigned_id});
    end
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          new_mask  = rbia_pkg::IdMaskReset;
          count     = 280;
          alloc_pct = 60;
        end
        1: begin
          new_mask  = IdW'($urandom);
          count     = 280;
          alloc_pct = 50;
        end
        2: begin
          new_mask  = '0;
          count     = 240;
          alloc_pct = 50;
        end
        default: begin
          // mostly allocations: the table fills and allocations start failing
          new_mask  = IdW'($urandom);
          count     = 1130;
          alloc_pct = 97;
        end
      endcase
      cfg_valid_i <= 1'b1;
      cfg_wdata_i <= new_mask;
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_valid_i <= 1'b0;
      mask_bits = new_mask;
      steady    = (ph == 1);
      if (ph == 0) hold_req <= hold_req + 1;

      for (int n = 0; n < count; n++) begin
        req_id = IdW'($urandom);
        cmd    = ($urandom_range(99) < alloc_pct) ? rbia_pkg::CmdAlloc : rbia_pkg::CmdFree;
        // most frees return an id that is still out, the rest hit any entry
        if (cmd == rbia_pkg::CmdFree && live_ids.size() > 0 && $urandom_range(99) < 80) begin
          pick   = $urandom_range(live_ids.size() - 1);
          req_id = live_ids[pick];
          live_ids.delete(pick);
        end
        issue_request(cmd, req_id, 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    steady = 1'b0;
    wait_idle();
    if (errors_seen == 0) begin
      $display("rotating_bitmap_id_allocator_core_tb passed");
    end else begin
      $display("rotating_bitmap_id_allocator_core_tb failed");
    end
    $finish;
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (holds_done < hold_req) begin
        holds_done++;
        hold_left = HoldOff;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < 6);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: status %0d, assigned_id %06h",
               status_o, assigned_id_o);
        errors_seen++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (status_o !== oldest_result.status) begin
          $error("status: expected %0d, actual %0d", oldest_result.status, status_o);
          errors_seen++;
        end
        if (assigned_id_o !== oldest_result.assigned_id) begin
          $error("assigned_id: expected %06h, actual %06h",
                 oldest_result.assigned_id, assigned_id_o);
          errors_seen++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("rotating_bitmap_id_allocator_core_tb failed");
    $finish;
  end

endmodule
